[rtl/arm_ik_pkg.sv]
// Shared types, constants and helper functions for the arm inverse kinematics pipeline.
package arm_ik_pkg;

  localparam int POS_W        = 14;
  localparam int LEN_W        = 8;
  localparam int OFS_W        = 9;
  localparam int DEG_W        = 8;
  localparam int ANG_FRAC     = 16;
  localparam int ANG_W        = 26;
  localparam int CORDIC_STEPS = 20;
  localparam int NORM_BITS    = 41;
  localparam int CX_W         = 45;
  localparam int SHW          = 6;
  localparam int ATAN_LAT     = CORDIC_STEPS + 4;
  localparam int DEG_TW       = 28;
  localparam int DEG_IW       = DEG_TW - ANG_FRAC;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;

  localparam logic signed [ANG_W-1:0] DEG45  = 26'sd2949120;
  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_45,
    SP_90
  } atan_sp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_LEN    = 3'd0,
    REG_LOWER_LEN    = 3'd1,
    REG_SHOULDER_OFS = 3'd2,
    REG_ELBOW_OFS    = 3'd3,
    REG_SERVO_LIMIT  = 3'd4
  } cfg_reg_t;

  // control bits that ride alongside a request
  typedef struct packed {
    logic valid;
    logic oor;
    logic a_neg;
  } ik_ctl_t;

  function automatic int pw_of(input int f);
    return 17 + 2 * f;
  endfunction

  function automatic int vw_of(input int f);
    return ((28 > pw_of(f)) ? 28 : pw_of(f)) + 2;
  endfunction

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic [ANG_W-1:0] atan_step(input int i);
    logic [ANG_W-1:0] r;
    case (i)
      0:  r = 26'd2949120;
      1:  r = 26'd1740967;
      2:  r = 26'd919879;
      3:  r = 26'd466945;
      4:  r = 26'd234379;
      5:  r = 26'd117304;
      6:  r = 26'd58666;
      7:  r = 26'd29335;
      8:  r = 26'd14668;
      9:  r = 26'd7334;
      10: r = 26'd3667;
      11: r = 26'd1833;
      12: r = 26'd917;
      13: r = 26'd458;
      14: r = 26'd229;
      15: r = 26'd115;
      16: r = 26'd57;
      17: r = 26'd29;
      18: r = 26'd14;
      19: r = 26'd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // whole degrees, rounded toward zero
  function automatic logic signed [DEG_IW-1:0] trunc_deg(input logic signed [DEG_TW-1:0] v);
    logic signed [DEG_TW-1:0] m;
    m = v[DEG_TW-1] ? -v : v;
    m = m >>> ANG_FRAC;
    return DEG_IW'(v[DEG_TW-1] ? -m : m);
  endfunction

endpackage

[rtl/two_link_arm_inverse_kinematics.sv]
// Two-link planar arm inverse kinematics: target point (x, y) in 1/2^POS_FRAC_BITS mm in,
// shoulder and elbow servo angles in whole degrees out, clamped to 0..servo_upper_limit.
// Fully pipelined: one request per clock, through a bit-per-stage square root and the
// 20-step CORDIC atan units; out_stall freezes the whole pipeline. Config writes are taken
// every cycle and must only happen while no request is in flight.
module two_link_arm_inverse_kinematics #(
  parameter int POS_FRAC_BITS = 4
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [arm_ik_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [arm_ik_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [arm_ik_pkg::POS_W-1:0]     target_x,
  input  logic signed [arm_ik_pkg::POS_W-1:0]     target_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [arm_ik_pkg::DEG_W-1:0]            shoulder_servo_deg,
  output logic [arm_ik_pkg::DEG_W-1:0]            elbow_servo_deg,
  output logic                                    limit_hit,
  output logic                                    out_of_reach
);
  import arm_ik_pkg::*;

  localparam int PW    = pw_of(POS_FRAC_BITS);
  localparam int VW    = vw_of(POS_FRAC_BITS);
  localparam int DW    = PW + 1;
  localparam int CW    = VW + 1;
  localparam int TAG_W = 2 + 2 * POS_W + 2 * VW;

  logic [LEN_W-1:0] upper_link_length, lower_link_length;
  logic [OFS_W-1:0] shoulder_offset_deg, elbow_offset_deg;
  logic [DEG_W-1:0] servo_upper_limit;

  logic adv;
  ik_ctl_t f_ctl;
  logic signed [POS_W-1:0] f_x, f_y, s_x, s_y;
  logic signed [VW-1:0] f_k, f_a, s_k, s_a;
  logic [2*DW-1:0] f_prod;
  logic [TAG_W-1:0] s_tag;
  logic s_valid, s_oor, s_aneg;
  logic [DW-1:0] s_root;
  logic signed [CW-1:0] n_root, d_bend, d_elbow;
  logic signed [ANG_W-1:0] z_target, z_bend, z_elbow;
  ik_ctl_t dl_q [ATAN_LAT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length   <= 8'd127;
      lower_link_length   <= 8'd127;
      shoulder_offset_deg <= 9'd215;
      elbow_offset_deg    <= 9'd125;
      servo_upper_limit   <= 8'd250;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_UPPER_LEN:    upper_link_length   <= cfg_data[LEN_W-1:0];
        REG_LOWER_LEN:    lower_link_length   <= cfg_data[LEN_W-1:0];
        REG_SHOULDER_OFS: shoulder_offset_deg <= cfg_data[OFS_W-1:0];
        REG_ELBOW_OFS:    elbow_offset_deg    <= cfg_data[OFS_W-1:0];
        REG_SERVO_LIMIT:  servo_upper_limit   <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished request is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  arm_ik_front #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .x        (target_x),
    .y        (target_y),
    .l1       (upper_link_length),
    .l2       (lower_link_length),
    .ctl      (f_ctl),
    .out_x    (f_x),
    .out_y    (f_y),
    .out_k    (f_k),
    .out_a    (f_a),
    .out_prod (f_prod)
  );

  arm_ik_sqrt #(
    .DW    (DW),
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_ctl.valid),
    .in_rad    (f_prod),
    .in_tag    ({f_ctl.oor, f_ctl.a_neg, f_x, f_y, f_k, f_a}),
    .out_valid (s_valid),
    .root      (s_root),
    .out_tag   (s_tag)
  );

  assign {s_oor, s_aneg, s_x, s_y, s_k, s_a} = s_tag;

  assign n_root  = $signed(CW'(s_root));
  assign d_bend  = CW'(s_k);
  assign d_elbow = s_aneg ? -CW'(s_a) : CW'(s_a);

  arm_ik_atan #(.CW(CW)) u_atan_target (
    .clk   (clk),
    .adv   (adv),
    .num   (CW'(s_y)),
    .den   (CW'(s_x)),
    .angle (z_target)
  );

  arm_ik_atan #(.CW(CW)) u_atan_bend (
    .clk   (clk),
    .adv   (adv),
    .num   (n_root),
    .den   (d_bend),
    .angle (z_bend)
  );

  arm_ik_atan #(.CW(CW)) u_atan_elbow (
    .clk   (clk),
    .adv   (adv),
    .num   (n_root),
    .den   (d_elbow),
    .angle (z_elbow)
  );

  // control bits matched to the atan latency
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ATAN_LAT; i++) begin
        dl_q[i] <= '0;
      end
    end else if (adv) begin
      dl_q[0] <= '{valid: s_valid, oor: s_oor, a_neg: s_aneg};
      for (int i = 1; i < ATAN_LAT; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  arm_ik_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ctl          (dl_q[ATAN_LAT-1]),
    .z_target     (z_target),
    .z_bend       (z_bend),
    .z_elbow      (z_elbow),
    .shoulder_ofs (shoulder_offset_deg),
    .elbow_ofs    (elbow_offset_deg),
    .limit        (servo_upper_limit),
    .out_valid    (out_valid),
    .shoulder_deg (shoulder_servo_deg),
    .elbow_deg    (elbow_servo_deg),
    .hit          (limit_hit),
    .oor          (out_of_reach)
  );

`ifndef SYNTHESIS
  a_oor_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_reach |-> !limit_hit)
    else $error("limit_hit set on unreachable request");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_reach |-> shoulder_servo_deg == '0 && elbow_servo_deg == '0)
    else $error("angles not zeroed on unreachable request");

  a_shoulder_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_reach |-> shoulder_servo_deg <= servo_upper_limit)
    else $error("shoulder angle above limit");

  a_elbow_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_reach |-> elbow_servo_deg <= servo_upper_limit)
    else $error("elbow angle above limit");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dl_q[ATAN_LAT-1]))
    else $error("pipeline moved while output held");
`endif

endmodule

[rtl/arm_ik_front.sv]
// Front end: squares, law-of-cosines terms, reach check and the radicand product.
module arm_ik_front #(
  parameter int POS_FRAC_BITS = 4
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  logic                                       in_valid,
  input  logic signed [arm_ik_pkg::POS_W-1:0]        x,
  input  logic signed [arm_ik_pkg::POS_W-1:0]        y,
  input  logic        [arm_ik_pkg::LEN_W-1:0]        l1,
  input  logic        [arm_ik_pkg::LEN_W-1:0]        l2,
  output arm_ik_pkg::ik_ctl_t                        ctl,
  output logic signed [arm_ik_pkg::POS_W-1:0]        out_x,
  output logic signed [arm_ik_pkg::POS_W-1:0]        out_y,
  output logic signed [arm_ik_pkg::vw_of(POS_FRAC_BITS)-1:0] out_k,
  output logic signed [arm_ik_pkg::vw_of(POS_FRAC_BITS)-1:0] out_a,
  output logic [2*(arm_ik_pkg::pw_of(POS_FRAC_BITS)+1)-1:0]  out_prod
);
  import arm_ik_pkg::*;

  localparam int SQW = 16 + 2 * POS_FRAC_BITS;
  localparam int PW  = pw_of(POS_FRAC_BITS);
  localparam int VW  = vw_of(POS_FRAC_BITS);
  localparam int DW  = PW + 1;
  localparam int PRW = 2 * DW;

  logic v1, v2, v3, v4;
  logic signed [POS_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [2*POS_W-1:0] xx_c, yy_c;
  logic [2*POS_W-2:0] xx1, yy1;
  logic [15:0] l1sq_c, l2sq_c, l12_c, l1sq1, l2sq1, l12_1;
  logic zl1, zl2;
  logic [2*POS_W-1:0] r2_c;
  logic [SQW-1:0] sq1_c, sq2_c;
  logic [PW-1:0] p_c;
  logic signed [VW-1:0] a_c, k_c, a2, k2, p2, a3, k3, a4, k4;
  logic oor3, oor4;
  logic [DW-1:0] dm3, dp3;
  logic [PRW-1:0] prod_c, prod4;

  assign xx_c   = (2*POS_W)'(x) * (2*POS_W)'(x);
  assign yy_c   = (2*POS_W)'(y) * (2*POS_W)'(y);
  assign l1sq_c = 16'(l1) * 16'(l1);
  assign l2sq_c = 16'(l2) * 16'(l2);
  assign l12_c  = 16'(l1) * 16'(l2);

  assign r2_c  = {1'b0, xx1} + {1'b0, yy1};
  assign sq1_c = SQW'(l1sq1) << (2 * POS_FRAC_BITS);
  assign sq2_c = SQW'(l2sq1) << (2 * POS_FRAC_BITS);
  assign p_c   = PW'(l12_1) << (2 * POS_FRAC_BITS + 1);
  assign a_c   = $signed(VW'(r2_c)) - $signed(VW'(sq1_c)) - $signed(VW'(sq2_c));
  assign k_c   = $signed(VW'(r2_c)) + $signed(VW'(sq1_c)) - $signed(VW'(sq2_c));

  assign prod_c = PRW'(dm3) * PRW'(dp3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= x;
      y1    <= y;
      xx1   <= xx_c[2*POS_W-2:0];
      yy1   <= yy_c[2*POS_W-2:0];
      l1sq1 <= l1sq_c;
      l2sq1 <= l2sq_c;
      l12_1 <= l12_c;
      zl1   <= (l1 == '0) || (l2 == '0);

      x2  <= x1;
      y2  <= y1;
      a2  <= a_c;
      k2  <= k_c;
      p2  <= $signed(VW'(p_c));
      zl2 <= zl1;

      x3   <= x2;
      y3   <= y2;
      a3   <= a2;
      k3   <= k2;
      oor3 <= zl2 || (a2 > p2) || (a2 < -p2);
      dm3  <= DW'(p2 - a2);
      dp3  <= DW'(p2 + a2);

      x4    <= x3;
      y4    <= y3;
      a4    <= a3;
      k4    <= k3;
      oor4  <= oor3;
      prod4 <= prod_c;
    end
  end

  assign ctl.valid = v4;
  assign ctl.oor   = oor4;
  assign ctl.a_neg = a4[VW-1];
  assign out_x     = x4;
  assign out_y     = y4;
  assign out_k     = k4;
  assign out_a     = a4;
  assign out_prod  = prod4;

endmodule

[rtl/arm_ik_sqrt.sv]
// Pipelined floor square root, one root bit per stage, with a side tag.
module arm_ik_sqrt #(
  parameter int DW    = 26,
  parameter int TAG_W = 90
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2*DW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [DW-1:0]     root,
  output logic [TAG_W-1:0]  out_tag
);
  import arm_ik_pkg::*;

  localparam int PRW = 2 * DW;
  localparam int RW  = PRW + 1;

  logic [PRW-1:0]   rem_q [DW];
  logic [RW-1:0]    res_q [DW];
  logic [TAG_W-1:0] tag_q [DW];
  logic [DW-1:0]    vld_q;

  for (genvar j = 0; j < DW; j++) begin : g_stage
    localparam logic [RW-1:0] BITC = RW'(1) << (2 * (DW - 1 - j));
    logic [PRW-1:0]   rem_i;
    logic [RW-1:0]    res_i;
    logic [TAG_W-1:0] tag_i;
    logic             vld_i;
    logic [RW-1:0]    trial;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_i = in_rad;
      assign res_i = '0;
      assign tag_i = in_tag;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_q[j-1];
      assign res_i = res_q[j-1];
      assign tag_i = tag_q[j-1];
      assign vld_i = vld_q[j-1];
    end

    assign trial = res_i + BITC;
    assign take  = {1'b0, rem_i} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[j] <= take ? rem_i - PRW'(trial) : rem_i;
        res_q[j] <= take ? (res_i >> 1) + BITC : (res_i >> 1);
        tag_q[j] <= tag_i;
      end
    end
  end

  assign out_valid = vld_q[DW-1];
  assign root      = res_q[DW-1][DW-1:0];
  assign out_tag   = tag_q[DW-1];

endmodule

[rtl/arm_ik_atan.sv]
// Pipelined plain atan(num/den) by CORDIC vectoring, result in degrees.
module arm_ik_atan #(
  parameter int CW = 31
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [CW-1:0]                num,
  input  logic signed [CW-1:0]                den,
  output logic signed [arm_ik_pkg::ANG_W-1:0] angle
);
  import arm_ik_pkg::*;

  logic signed [CW-1:0] nn_c, dd_c;
  logic [CW-1:0] mag_c, mag1, dd1, mag2, dd2, or_v;
  logic neg_c, neg1, neg2;
  atan_sp_t sp_c, sp1, sp2;
  logic [SHW-1:0] bl_c, sh2;

  logic signed [CX_W-1:0]  cx_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  cy_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q  [CORDIC_STEPS+1];
  logic                    ng_q [CORDIC_STEPS+1];
  atan_sp_t                sp_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] r_c;

  // fold into den >= 0, record sign of the quotient and exact cases
  always_comb begin
    nn_c  = den[CW-1] ? -num : num;
    dd_c  = den[CW-1] ? -den : den;
    mag_c = nn_c[CW-1] ? $unsigned(-nn_c) : $unsigned(nn_c);
    if (den == '0) begin
      neg_c = num[CW-1];
      sp_c  = (num == '0) ? SP_ZERO : SP_90;
    end else begin
      neg_c = nn_c[CW-1];
      if (mag_c == '0) begin
        sp_c = SP_ZERO;
      end else if (mag_c == $unsigned(dd_c)) begin
        sp_c = SP_45;
      end else begin
        sp_c = SP_NONE;
      end
    end
  end

  assign or_v = mag1 | dd1;

  always_comb begin
    bl_c = '0;
    for (int i = 0; i < CW; i++) begin
      if (or_v[i]) begin
        bl_c = SHW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1 <= mag_c;
      dd1  <= $unsigned(dd_c);
      neg1 <= neg_c;
      sp1  <= sp_c;

      mag2 <= mag1;
      dd2  <= dd1;
      neg2 <= neg1;
      sp2  <= sp1;
      sh2  <= SHW'(NORM_BITS) - bl_c;

      // scale both so the larger lands in [2^40, 2^41)
      cx_q[0] <= $signed(CX_W'(dd2) << sh2);
      cy_q[0] <= $signed(CX_W'(mag2) << sh2);
      z_q[0]  <= '0;
      ng_q[0] <= neg2;
      sp_q[0] <= sp2;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP = $signed(atan_step(i));
    logic signed [CX_W-1:0] dx, dy;
    logic                   pos;

    assign dx  = cy_q[i] >>> i;
    assign dy  = cx_q[i] >>> i;
    assign pos = cy_q[i] > 0;

    always_ff @(posedge clk) begin
      if (adv) begin
        cx_q[i+1] <= pos ? cx_q[i] + dx : cx_q[i] - dx;
        cy_q[i+1] <= pos ? cy_q[i] - dy : cy_q[i] + dy;
        z_q[i+1]  <= pos ? z_q[i] + STEP : z_q[i] - STEP;
        ng_q[i+1] <= ng_q[i];
        sp_q[i+1] <= sp_q[i];
      end
    end
  end

  always_comb begin
    case (sp_q[CORDIC_STEPS])
      SP_NONE: r_c = z_q[CORDIC_STEPS];
      SP_ZERO: r_c = '0;
      SP_45:   r_c = DEG45;
      SP_90:   r_c = DEG90;
      default: r_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle <= ng_q[CORDIC_STEPS] ? -r_c : r_c;
    end
  end

endmodule

[rtl/arm_ik_back.sv]
// Back end: joint angles to servo degrees, truncation, clamping and output register.
module arm_ik_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  arm_ik_pkg::ik_ctl_t                 ctl,
  input  logic signed [arm_ik_pkg::ANG_W-1:0] z_target,
  input  logic signed [arm_ik_pkg::ANG_W-1:0] z_bend,
  input  logic signed [arm_ik_pkg::ANG_W-1:0] z_elbow,
  input  logic        [arm_ik_pkg::OFS_W-1:0] shoulder_ofs,
  input  logic        [arm_ik_pkg::OFS_W-1:0] elbow_ofs,
  input  logic        [arm_ik_pkg::DEG_W-1:0] limit,
  output logic                                out_valid,
  output logic        [arm_ik_pkg::DEG_W-1:0] shoulder_deg,
  output logic        [arm_ik_pkg::DEG_W-1:0] elbow_deg,
  output logic                                hit,
  output logic                                oor
);
  import arm_ik_pkg::*;

  logic signed [ANG_W:0]    th1_c, th2_c;
  logic signed [DEG_TW-1:0] dv1_c, dv2_c, dv1, dv2;
  logic                     v1, oor1;
  logic signed [DEG_IW-1:0] q1_c, q2_c;
  logic signed [DEG_IW-1:0] lim_s;
  logic [DEG_W-1:0]         s_c, e_c;
  logic                     hs_c, he_c;

  assign th1_c = (ANG_W+1)'(z_target) - (ANG_W+1)'(z_bend);
  assign th2_c = ctl.a_neg ? (ANG_W+1)'(DEG180) - (ANG_W+1)'(z_elbow)
                           : (ANG_W+1)'(z_elbow);
  assign dv1_c = $signed(DEG_TW'(shoulder_ofs) << ANG_FRAC) - DEG_TW'(th1_c);
  assign dv2_c = $signed(DEG_TW'(elbow_ofs) << ANG_FRAC) - DEG_TW'(th2_c);

  assign q1_c  = trunc_deg(dv1);
  assign q2_c  = trunc_deg(dv2);
  assign lim_s = $signed(DEG_IW'(limit));

  always_comb begin
    hs_c = 1'b1;
    if (q1_c > lim_s) begin
      s_c = limit;
    end else if (q1_c < 0) begin
      s_c = '0;
    end else begin
      s_c  = q1_c[DEG_W-1:0];
      hs_c = 1'b0;
    end
    he_c = 1'b1;
    if (q2_c > lim_s) begin
      e_c = limit;
    end else if (q2_c < 0) begin
      e_c = '0;
    end else begin
      e_c  = q2_c[DEG_W-1:0];
      he_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= ctl.valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv1  <= dv1_c;
      dv2  <= dv2_c;
      oor1 <= ctl.oor;

      shoulder_deg <= oor1 ? '0 : s_c;
      elbow_deg    <= oor1 ? '0 : e_c;
      hit          <= oor1 ? 1'b0 : (hs_c || he_c);
      oor          <= oor1;
    end
  end

endmodule

[tb/sv/two_link_arm_inverse_kinematics_test.sv]
// Testbench for the two-link arm inverse kinematics pipeline: scoreboard plus stimulus.
`timescale 1ns / 1ps

module two_link_arm_inverse_kinematics_test;
  import arm_ik_pkg::*;

  typedef struct {
    logic [DEG_W-1:0] shoulder;
    logic [DEG_W-1:0] elbow;
    logic             hit;
    logic             oor;
  } servo_result_t;

  class servo_scoreboard;
    logic [LEN_W-1:0] len1, len2, lim;
    logic [OFS_W-1:0] ofs_sh, ofs_el;
    servo_result_t    pending_angles[$];
    int               errors;
    longint           step_tab[CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function void reset_regs();
      len1 = 127; len2 = 127; ofs_sh = 215; ofs_el = 125; lim = 250;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_UPPER_LEN:    len1 = val[7:0];
        REG_LOWER_LEN:    len2 = val[7:0];
        REG_SHOULDER_OFS: ofs_sh = val;
        REG_ELBOW_OFS:    ofs_el = val;
        REG_SERVO_LIMIT:  lim = val[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else res >>= 1;
        bit_w >>= 2;
      end
      return res;
    endfunction

    function longint vector_atan(longint unsigned n, longint unsigned d);
      longint cx, cy, z, dx, dy;
      z = 0;
      if (n == 0) return 0;
      if (n == d) return longint'(45) << ANG_FRAC;
      while (n < (64'd1 << 40) && d < (64'd1 << 40)) begin
        n <<= 1;
        d <<= 1;
      end
      cx = d;
      cy = n;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx += dx; cy -= dy; z += step_tab[i];
        end else begin
          cx -= dx; cy += dy; z -= step_tab[i];
        end
      end
      return z;
    endfunction

    // plain atan of n/d, -90..90 degrees; zero divisor gives +-90 or 0
    function longint ratio_atan(longint n, longint d);
      longint z;
      bit neg;
      if (d == 0) return n > 0 ? (longint'(90) << ANG_FRAC) :
                         (n < 0 ? -(longint'(90) << ANG_FRAC) : 0);
      if (d < 0) begin
        n = -n; d = -d;
      end
      neg = n < 0;
      z = vector_atan(neg ? -n : n, d);
      return neg ? -z : z;
    endfunction

    function longint whole_deg(longint v);
      return v >= 0 ? (v >>> ANG_FRAC) : -((-v) >>> ANG_FRAC);
    endfunction

    function servo_result_t solve_angles(logic signed [POS_W-1:0] tx,
                                         logic signed [POS_W-1:0] ty);
      servo_result_t r;
      longint x, y, l1, l2, r2, sq1, sq2, a, p, k, s, th1, th2, d1, d2, lim_l;
      x = tx; y = ty; l1 = len1; l2 = len2; lim_l = longint'(lim);
      r = '{shoulder: 0, elbow: 0, hit: 0, oor: 1};
      if (l1 == 0 || l2 == 0) return r;
      r2 = x * x + y * y;
      sq1 = l1 * l1 * 256;
      sq2 = l2 * l2 * 256;
      a = r2 - sq1 - sq2;
      p = 2 * l1 * l2 * 256;
      if (a > p || a < -p) return r;
      s = int_sqrt(longint'(p - a) * longint'(p + a));
      k = r2 + sq1 - sq2;
      th1 = ratio_atan(y, x) - ratio_atan(s, k);
      if (a >= 0) th2 = ratio_atan(s, a);
      else th2 = (longint'(180) << ANG_FRAC) - ratio_atan(s, -a);
      d1 = whole_deg((longint'(ofs_sh) << ANG_FRAC) - th1);
      d2 = whole_deg((longint'(ofs_el) << ANG_FRAC) - th2);
      r.oor = 0;
      if (d1 > lim_l) begin d1 = lim_l; r.hit = 1; end
      else if (d1 < 0) begin d1 = 0; r.hit = 1; end
      if (d2 > lim_l) begin d2 = lim_l; r.hit = 1; end
      else if (d2 < 0) begin d2 = 0; r.hit = 1; end
      r.shoulder = d1[7:0];
      r.elbow = d2[7:0];
      return r;
    endfunction

    function void note_request(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty);
      pending_angles.push_back(solve_angles(tx, ty));
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t want;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result sh=%0d el=%0d hit=%0d oor=%0d",
                 $time, got.shoulder, got.elbow, got.hit, got.oor);
        errors++;
        return;
      end
      want = pending_angles.pop_front();
      if (got.shoulder !== want.shoulder) begin
        $display("%0t: shoulder expected %0d got %0d", $time, want.shoulder, got.shoulder);
        errors++;
      end
      if (got.elbow !== want.elbow) begin
        $display("%0t: elbow expected %0d got %0d", $time, want.elbow, got.elbow);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $display("%0t: limit_hit expected %0d got %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.oor !== want.oor) begin
        $display("%0t: out_of_reach expected %0d got %0d", $time, want.oor, got.oor);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic                         clk = 0;
  logic                         rst = 1;
  logic                         cfg_valid = 0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 0;
  logic                         in_stall;
  logic signed [POS_W-1:0]      target_x = '0;
  logic signed [POS_W-1:0]      target_y = '0;
  logic                         out_valid;
  logic                         out_stall = 0;
  logic [DEG_W-1:0]             shoulder_servo_deg;
  logic [DEG_W-1:0]             elbow_servo_deg;
  logic                         limit_hit;
  logic                         out_of_reach;

  servo_scoreboard sb = new();
  int              burst_left = 0;
  int              results_seen = 0;
  int              idle_cycles = 0;

  two_link_arm_inverse_kinematics i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .target_x(target_x), .target_y(target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .shoulder_servo_deg(shoulder_servo_deg), .elbow_servo_deg(elbow_servo_deg),
    .limit_hit(limit_hit), .out_of_reach(out_of_reach)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(target_x, target_y);
      if (out_valid && !out_stall) begin
        sb.check_result('{shoulder: shoulder_servo_deg, elbow: elbow_servo_deg,
                          hit: limit_hit, oor: out_of_reach});
        results_seen++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("two_link_arm_inverse_kinematics_test NOT OK");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold once 150 results have been seen
  initial begin
    int mode;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 2);
      for (int c = 0; c < 50; c++) begin
        @(posedge clk);
        if (!held && results_seen >= 150) begin
          held = 1;
          out_stall <= 1;
          repeat (400) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(int x, int y);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1;
    target_x <= x[POS_W-1:0];
    target_y <= y[POS_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // mostly reachable points inside the arm's square, the rest over the whole field
  task automatic random_points(int n);
    int reach, x, y;
    reach = (int'(sb.len1) + int'(sb.len2)) * 16;
    if (reach > 8191) reach = 8191;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        x = int'($urandom_range(0, 2 * reach)) - reach;
        y = int'($urandom_range(0, 2 * reach)) - reach;
      end else begin
        x = int'($signed(14'($urandom)));
        y = int'($signed(14'($urandom)));
      end
      send_point(x, y);
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: folded origin, elbow at right angle (zero divisor; n equals d for the other atans), axes, extremes
    send_point(0, 0);       send_point(2032, 2032);  send_point(-2032, 2032);
    send_point(0, 100);     send_point(0, -100);     send_point(100, 0);
    send_point(-100, 0);    send_point(8191, 8191);  send_point(-8192, -8192);
    send_point(8191, 0);    send_point(-8192, 0);    send_point(0, 8191);
    send_point(1, 0);       send_point(-1, -1);      send_point(4064, 0);
    send_point(-4064, 0);   send_point(0, 4064);     send_point(10, -3000);
    random_points(230);
    drain();

    write_reg(REG_UPPER_LEN, 1);
    write_reg(REG_LOWER_LEN, 1);
    write_reg(REG_SHOULDER_OFS, 0);
    write_reg(REG_ELBOW_OFS, 0);
    write_reg(REG_SERVO_LIMIT, 0);
    send_point(0, 0);  send_point(32, 0);  send_point(0, -32);  send_point(16, 16);
    random_points(200);
    drain();

    write_reg(REG_UPPER_LEN, 255);
    write_reg(REG_LOWER_LEN, 255);
    write_reg(REG_SHOULDER_OFS, 360);
    write_reg(REG_ELBOW_OFS, 360);
    write_reg(REG_SERVO_LIMIT, 255);
    write_reg(3'd7, 9'h1ff);
    send_point(8191, 0);  send_point(-8192, 8191);  send_point(0, 0);
    random_points(200);
    drain();

    // offsets beyond a full turn, unequal links
    write_reg(REG_UPPER_LEN, 200);
    write_reg(REG_LOWER_LEN, 40);
    write_reg(REG_SHOULDER_OFS, 511);
    write_reg(REG_ELBOW_OFS, 400);
    write_reg(REG_SERVO_LIMIT, 128);
    write_reg(3'd5, 9'h0aa);
    send_point(0, 0);  send_point(2560, 0);  send_point(0, -3840);
    random_points(200);
    drain();

    // zero link length: every point out of reach
    write_reg(REG_LOWER_LEN, 256);
    send_point(0, 0);  send_point(100, 100);
    random_points(100);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(REG_UPPER_LEN, CFG_DATA_W'($urandom_range(1, 255)));
      write_reg(REG_LOWER_LEN, CFG_DATA_W'($urandom_range(1, 255)));
      write_reg(REG_SHOULDER_OFS, CFG_DATA_W'($urandom_range(0, 360)));
      write_reg(REG_ELBOW_OFS, CFG_DATA_W'($urandom_range(0, 360)));
      write_reg(REG_SERVO_LIMIT, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(3'd6, CFG_DATA_W'($urandom_range(0, 511)));
      random_points(150);
      drain();
    end

    if (sb.errors == 0) $display("two_link_arm_inverse_kinematics_test OK");
    else $display("two_link_arm_inverse_kinematics_test NOT OK");
    $finish;
  end

endmodule
